@@ sv/rrlm_pkg.sv @@
// ----------------------------------------------------------------------------
// rrlm_pkg
// Shared types and constants of the request/response latency matcher.
// ----------------------------------------------------------------------------
package rrlm_pkg;

  localparam int FLOWS_DEF = 1024;
  localparam int PROBES    = 4;
  localparam int KEY_W     = 48;
  localparam int SEQ_W     = 32;
  localparam int LEN_W     = 16;
  localparam int TS_W      = 48;
  localparam int CNT_W     = 32;
  localparam int IN_W      = 160;  // 154 bits of fields, padded to whole bytes
  localparam int OUT_W     = 248;  // 245 bits of fields, padded to whole bytes
  localparam logic [31:0] TIMEOUT_RESET = 32'd50000000;
  localparam logic [63:0] HASH_MULT     = 64'h9E3779B97F4A7C15;

  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_RSP  = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [1:0] PRI_LOW     = 2'd0;
  localparam logic [1:0] PRI_HI      = 2'd1;
  localparam logic [1:0] PRI_UNKNOWN = 2'd2;

  localparam logic [0:0] REG_LABEL   = 1'b0;
  localparam logic [0:0] REG_TIMEOUT = 1'b1;

  typedef enum logic [3:0] {
    ST_REQ_NEW     = 4'd0,
    ST_REQ_RETX    = 4'd1,
    ST_SAMPLE      = 4'd2,
    ST_WINDOW      = 4'd3,
    ST_UNMATCHED   = 4'd4,
    ST_NOT_LATER   = 4'd5,
    ST_RSP_RETX    = 4'd6,
    ST_FULL        = 4'd7,
    ST_REPORT      = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    FSM_CLEAR, FSM_IDLE, FSM_HASH, FSM_READ, FSM_DECIDE, FSM_WRITE, FSM_OUT, FSM_SWEEP
  } fsm_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture input item
    logic hash;       // register the hash partial products
    logic decide;     // evaluate the item and register the result
    logic write;      // write back entry (counters update on decide)
    logic sweep_rst;  // clear pass over keys, times and flow state (after reset)
    logic sweep_end;  // clear pass over flow state (interval end)
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       sweep_done;
  } stat_t;

endpackage

@@ sv/rrlm_ram.sv @@
// ----------------------------------------------------------------------------
// rrlm_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rrlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/rrlm_datapath.sv @@
// ----------------------------------------------------------------------------
// rrlm_datapath
// Flow table banks, probe compare, entry update, counters and result register.
// ----------------------------------------------------------------------------
module rrlm_datapath #(
  parameter int FLOWS = rrlm_pkg::FLOWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rrlm_pkg::cmd_t               cmd,
  output rrlm_pkg::stat_t              stat,
  input  logic [rrlm_pkg::IN_W-1:0]    in_data,
  input  logic [7:0]                   label,
  input  logic [31:0]                  timeout,
  output logic [rrlm_pkg::OUT_W-1:0]   out_data
);
  import rrlm_pkg::*;

  localparam int AW = $clog2(FLOWS);
  localparam int BW = AW - 2;
  localparam int DEPTH_B = FLOWS / PROBES;
  // Flow state kept per entry: request seq, response seq, len, seen, priority.
  localparam int FS_W = SEQ_W + SEQ_W + LEN_W + 1 + 2;

  // Item fields.
  logic [1:0]       kind;
  logic [KEY_W-1:0] key;
  logic [SEQ_W-1:0] seq;
  logic [LEN_W-1:0] len;
  logic [7:0]       pri;
  logic [TS_W-1:0]  ts;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= in_data[1:0];
      key  <= {in_data[33:2], in_data[49:34]};
      seq  <= in_data[81:50];
      len  <= in_data[97:82];
      pri  <= in_data[105:98];
      ts   <= in_data[153:106];
    end
  end
  assign stat.kind = kind;

  // Home slot: multiplicative hash, bits above 32 taken modulo FLOWS. Only the
  // low 48 product bits matter, so three 24 x 24 partial products are enough.
  logic [47:0]   mul_ll, p_ll, hsum;
  logic [23:0]   mul_x, p_x;
  logic [AW-1:0] home;
  always_comb begin
    mul_ll = {24'd0, key[23:0]} * {24'd0, HASH_MULT[23:0]};
    mul_x  = key[47:24] * HASH_MULT[23:0] + key[23:0] * HASH_MULT[47:24];
  end
  always_ff @(posedge clk) begin
    if (cmd.hash) begin
      p_ll <= mul_ll;
      p_x  <= mul_x;
    end
  end
  assign hsum = p_ll + {p_x, 24'd0};
  assign home = hsum[32 +: AW];

  // Clear pass address; every bank is written at the same address per cycle.
  logic [BW-1:0] sweep;
  logic          sweep_any;
  assign sweep_any = cmd.sweep_rst || cmd.sweep_end;
  always_ff @(posedge clk) begin
    if (rst || !sweep_any) begin
      sweep <= '0;
    end else begin
      sweep <= sweep + BW'(1);
    end
  end
  assign stat.sweep_done = &sweep;

  // Banks: bank b holds slots with slot mod PROBES == b, so all probe slots are
  // read in parallel. The key bank carries the entry valid bit on top.
  logic [FS_W-1:0]  fs_bk  [PROBES];
  logic [KEY_W:0]   key_bk [PROBES];
  logic [TS_W-1:0]  tim_bk [PROBES];
  logic [AW-1:0]    wslot;
  logic [FS_W-1:0]  fs_wd;
  logic             fs_we, key_we, tim_we;

  for (genvar p = 0; p < PROBES; p++) begin : g_bank
    logic [1:0]    b_sel;
    logic [AW-1:0] rs;
    logic          wb;
    logic [BW-1:0] wa;
    always_comb begin
      b_sel = 2'(p) - home[1:0];
      rs    = home + AW'(b_sel);
      wb    = (wslot[1:0] == 2'(p));
      wa    = sweep_any ? sweep : wslot[AW-1:2];
    end
    rrlm_ram #(.WIDTH(FS_W), .DEPTH(DEPTH_B)) u_fs (
      .clk(clk), .we(sweep_any || (fs_we && wb)), .waddr(wa),
      .wdata(sweep_any ? '0 : fs_wd), .raddr(rs[AW-1:2]), .rdata(fs_bk[p]));
    rrlm_ram #(.WIDTH(KEY_W + 1), .DEPTH(DEPTH_B)) u_key (
      .clk(clk), .we(cmd.sweep_rst || (key_we && wb)), .waddr(wa),
      .wdata(cmd.sweep_rst ? '0 : {1'b1, key}), .raddr(rs[AW-1:2]), .rdata(key_bk[p]));
    rrlm_ram #(.WIDTH(TS_W), .DEPTH(DEPTH_B)) u_tim (
      .clk(clk), .we(cmd.sweep_rst || (tim_we && wb)), .waddr(wa),
      .wdata(cmd.sweep_rst ? '0 : ts), .raddr(rs[AW-1:2]), .rdata(tim_bk[p]));
  end

  // Bank outputs put back into probe order.
  logic [FS_W-1:0]  fs_rd  [PROBES];
  logic [KEY_W:0]   key_rd [PROBES];
  logic [TS_W-1:0]  tim_rd [PROBES];
  always_comb begin
    for (int i = 0; i < PROBES; i++) begin
      fs_rd[i]  = fs_bk[home[1:0] + 2'(i)];
      key_rd[i] = key_bk[home[1:0] + 2'(i)];
      tim_rd[i] = tim_bk[home[1:0] + 2'(i)];
    end
  end

  // Probe search: first matching slot and first free slot.
  logic          hit, has_free;
  logic [1:0]    hidx, fidx;
  always_comb begin
    hit = 1'b0; hidx = '0; has_free = 1'b0; fidx = '0;
    for (int i = PROBES - 1; i >= 0; i--) begin
      if (key_rd[i][KEY_W] && key_rd[i][KEY_W-1:0] == key) begin
        hit = 1'b1; hidx = 2'(i);
      end
      if (!key_rd[i][KEY_W]) begin
        has_free = 1'b1; fidx = 2'(i);
      end
    end
  end

  logic [1:0]      sel;
  logic [SEQ_W-1:0] e_rseq, e_pseq;
  logic [LEN_W-1:0] e_len;
  logic             e_seen;
  logic [1:0]       e_pri;
  logic [TS_W-1:0]  e_time;
  always_comb begin
    sel = hit ? hidx : fidx;
    {e_rseq, e_pseq, e_len, e_seen, e_pri} = fs_rd[sel];
    e_time = tim_rd[sel];
  end

  // Counters.
  logic [CNT_W-1:0] c_new, c_rqx, c_rsx, c_hi, c_lo, c_to;
  logic             inc_new, inc_rqx, inc_rsx, inc_hi, inc_lo, inc_to;

  status_t          st;
  logic [TS_W-1:0]  lat;
  logic             high;
  logic             wr_fs, wr_key, wr_tim;
  logic [FS_W-1:0]  fs_new;
  logic [SEQ_W-1:0] dseq;
  always_comb begin
    st = ST_REPORT; wr_fs = 1'b0; wr_key = 1'b0; wr_tim = 1'b0;
    inc_new = 1'b0; inc_rqx = 1'b0; inc_rsx = 1'b0; inc_hi = 1'b0; inc_lo = 1'b0;
    inc_to = 1'b0;
    lat = ts - e_time;
    high = (e_pri != PRI_LOW);
    dseq = seq - e_rseq;
    fs_new = {e_rseq, e_pseq, e_len, e_seen, e_pri};
    if (kind == KIND_REQ) begin
      if (!hit && !has_free) begin
        st = ST_FULL;
      end else begin
        wr_fs = 1'b1;
        wr_key = !hit;
        if (seq > e_rseq) begin
          st = ST_REQ_NEW;
          inc_new = !e_seen;
          wr_tim = 1'b1;
          fs_new = {seq, e_pseq, len, 1'b1, (pri == label) ? PRI_HI : PRI_LOW};
        end else begin
          st = ST_REQ_RETX;
          inc_rqx = 1'b1;
          fs_new = {e_rseq, e_pseq, e_len, e_seen, (pri == label) ? PRI_HI : PRI_LOW};
        end
      end
    end else if (kind == KIND_RSP) begin
      if (!hit) begin
        st = ST_UNMATCHED;
      end else if (dseq > SEQ_W'(e_len)) begin
        st = ST_WINDOW;
      end else if (ts <= e_time) begin
        st = ST_NOT_LATER;
      end else if (seq > e_pseq) begin
        st = ST_SAMPLE;
        wr_fs = 1'b1;
        fs_new = {e_rseq, seq, e_len, e_seen, e_pri};
        inc_hi = high; inc_lo = !high;
        inc_to = lat > TS_W'(timeout);
      end else begin
        st = ST_RSP_RETX;
        inc_rsx = 1'b1;
      end
    end
  end

  // Registered decision, written back in the next step.
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      wslot <= home + AW'(sel);
      fs_wd <= fs_new;
    end
  end
  logic wr_fs_q, wr_key_q, wr_tim_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_fs_q <= 1'b0; wr_key_q <= 1'b0; wr_tim_q <= 1'b0;
    end else if (cmd.decide) begin
      wr_fs_q <= wr_fs; wr_key_q <= wr_key; wr_tim_q <= wr_tim;
    end
  end
  assign fs_we  = cmd.write && wr_fs_q;
  assign key_we = cmd.write && wr_key_q;
  assign tim_we = cmd.write && wr_tim_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_new <= '0; c_rqx <= '0; c_rsx <= '0; c_hi <= '0; c_lo <= '0; c_to <= '0;
    end else if (cmd.decide) begin
      if (kind == KIND_END) begin
        c_new <= '0; c_rqx <= '0; c_rsx <= '0; c_hi <= '0; c_lo <= '0;
      end else begin
        c_new <= c_new + CNT_W'(inc_new);
        c_rqx <= c_rqx + CNT_W'(inc_rqx);
        c_rsx <= c_rsx + CNT_W'(inc_rsx);
        c_hi  <= c_hi + CNT_W'(inc_hi);
        c_lo  <= c_lo + CNT_W'(inc_lo);
        c_to  <= c_to + CNT_W'(inc_to);
      end
    end
  end

  // Result register.
  logic [OUT_W-1:0] out_next;
  always_comb begin
    out_next = '0;
    out_next[3:0] = st;
    if (st == ST_SAMPLE) begin
      out_next[51:4] = lat;
      out_next[52]   = high;
    end
    if (kind == KIND_END) begin
      out_next[84:53]   = c_new;
      out_next[116:85]  = c_rqx;
      out_next[148:117] = c_rsx;
      out_next[180:149] = c_hi;
      out_next[212:181] = c_lo;
      out_next[244:213] = c_to;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      out_data <= out_next;
    end
  end
endmodule

@@ sv/rrlm_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrlm_ctrl
// Item sequencer: hash, read, decide, write back or clear, present result.
// ----------------------------------------------------------------------------
module rrlm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      in_kind,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output rrlm_pkg::cmd_t  cmd,
  input  rrlm_pkg::stat_t stat
);
  import rrlm_pkg::*;

  fsm_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FSM_CLEAR:  if (stat.sweep_done) state_next = FSM_IDLE;
      FSM_IDLE:   if (in_valid && in_kind != KIND_NONE) state_next = FSM_HASH;
      FSM_HASH:   state_next = FSM_READ;
      FSM_READ:   state_next = FSM_DECIDE;
      FSM_DECIDE: state_next = (stat.kind == KIND_END) ? FSM_SWEEP : FSM_WRITE;
      FSM_WRITE:  state_next = FSM_OUT;
      FSM_OUT:    if (out_ready) state_next = FSM_IDLE;
      FSM_SWEEP:  if (stat.sweep_done) state_next = FSM_OUT;
      default:    state_next = FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      FSM_CLEAR:  cmd.sweep_rst = 1'b1;
      FSM_IDLE: begin
        in_ready = 1'b1;
        cmd.load = 1'b1;
      end
      FSM_HASH:   cmd.hash = 1'b1;
      FSM_DECIDE: cmd.decide = 1'b1;
      FSM_WRITE:  cmd.write = 1'b1;
      FSM_OUT:    out_valid = 1'b1;
      FSM_SWEEP:  cmd.sweep_end = 1'b1;
      default: ;
    endcase
  end
endmodule

@@ sv/request_response_latency_matcher.sv @@
// ----------------------------------------------------------------------------
// request_response_latency_matcher
// Matches requests to responses per flow and reports latency and counters.
// ----------------------------------------------------------------------------
// Each item passes through the hash, probe read, decide and write back steps
// before its result is presented. An interval end replaces the write back by
// a clear pass over the FLOWS/PROBES flow state addresses (256 by default).
// The entry is read, modified and written back before a new item is taken,
// and only once the previous result is accepted. Reset is synchronous and is
// followed by a clear pass during which s_axis_tready stays low.
module request_response_latency_matcher #(
  parameter int FLOWS = rrlm_pkg::FLOWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // kind, flow_addr, flow_port, seq_number, payload_bytes, priority_byte,
  // timestamp_ns from bit 0 up
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [rrlm_pkg::IN_W-1:0]   s_axis_tdata,
  // status, latency_ns, sample_high_priority, new_flows, request_retransmits,
  // response_retransmits, high_samples, low_samples, timeouts from bit 0 up
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [rrlm_pkg::OUT_W-1:0]  m_axis_tdata,
  // Register writes: index 0 is high_priority_label, index 1 is timeout_ns.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [31:0]                 cfg_data
);
  import rrlm_pkg::*;

  logic [7:0]  label;
  logic [31:0] timeout;
  cmd_t        cmd;
  stat_t       stat;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      label   <= '0;
      timeout <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LABEL:   label   <= cfg_data[7:0];
        REG_TIMEOUT: timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  rrlm_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_kind(s_axis_tdata[1:0]), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd(cmd), .stat(stat));

  rrlm_datapath #(.FLOWS(FLOWS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_data(s_axis_tdata), .label(label), .timeout(timeout),
    .out_data(m_axis_tdata));
endmodule
